// File: rtl/agl_pkg.sv
// Shared constants and types of the antialiased gradient line rasterizer.
`timescale 1ns / 1ps

package agl_pkg;

    localparam int TILE_SIZE     = 64;
    localparam int FRACTION_BITS = 16;

    localparam int COORD_W     = $clog2(TILE_SIZE);
    localparam int COLOR_W     = 8;
    localparam int SIDE_W      = COORD_W + 2;
    localparam int E_W         = FRACTION_BITS + 1;
    localparam int PROD_W      = COORD_W + E_W;
    localparam int DIV_W       = COORD_W + FRACTION_BITS;
    localparam int COLOR_NUM_W = COORD_W + COLOR_W;
    localparam int CNT_W       = $clog2(DIV_W + 1);

    localparam logic [E_W-1:0] E_ONE = E_W'(1) << FRACTION_BITS;

    typedef struct packed {
        logic start;
        logic long_div;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/agl_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module agl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  agl_pkg::t_div_req             i_req,
    input  logic [agl_pkg::DIV_W-1:0]     i_dividend,
    input  logic [agl_pkg::COORD_W-1:0]   i_divisor,
    output agl_pkg::t_div_rsp             o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [agl_pkg::CNT_W-1:0]     r_cnt;
    logic [agl_pkg::DIV_W-1:0]     r_num;
    logic [agl_pkg::DIV_W-1:0]     r_quo;
    logic [agl_pkg::COORD_W-1:0]   r_rem;

    logic [agl_pkg::COORD_W:0]     w_trial;
    logic [agl_pkg::COORD_W:0]     w_diff;
    logic                          w_fit;

    assign w_trial = {r_rem, r_num[agl_pkg::DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.long_div ? agl_pkg::CNT_W'(agl_pkg::DIV_W)
                                     : agl_pkg::CNT_W'(agl_pkg::COLOR_NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - agl_pkg::CNT_W'(1);
            if (r_cnt == agl_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_num <= i_req.long_div
                ? i_dividend
                : i_dividend << (agl_pkg::DIV_W - agl_pkg::COLOR_NUM_W);
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[agl_pkg::COORD_W-1:0] : w_trial[agl_pkg::COORD_W-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[agl_pkg::DIV_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/antialiased_gradient_line.sv
// Top level of the antialiased gradient line rasterizer with pen state.
`timescale 1ns / 1ps

// A move command only sets the pen. A line command first runs the slope
// division, which a vertical line skips, then passes for every pixel pair
// through the states MUL_M, DIV_M, MUL_S, DIV_S, DIV_B and EMIT; a vertical
// line skips MUL_S and DIV_S. The pace is set by the single bit-serial
// divider, used in turn for the slope step and for the main red, side red
// and blue of every pair (only main red and blue on a vertical line), each
// colour a quotient by the line length. The block takes no new command
// until the last pair of a line has been loaded into the output register.
module antialiased_gradient_line (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [agl_pkg::COORD_W-1:0]   i_x_coord,
    input  logic [agl_pkg::COORD_W-1:0]   i_y_coord,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [agl_pkg::COORD_W-1:0]   o_main_x,
    output logic [agl_pkg::COORD_W-1:0]   o_main_y,
    output logic [agl_pkg::COLOR_W-1:0]   o_main_red,
    output logic signed [agl_pkg::SIDE_W-1:0] o_side_x,
    output logic signed [agl_pkg::SIDE_W-1:0] o_side_y,
    output logic [agl_pkg::COLOR_W-1:0]   o_side_red,
    output logic                          o_side_valid,
    output logic [agl_pkg::COLOR_W-1:0]   o_blue_level,
    output logic                          o_last_pair
);

    localparam int CW = agl_pkg::COORD_W;
    localparam int FB = agl_pkg::FRACTION_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INC   = 3'd1;
    localparam logic [2:0] S_MUL_M = 3'd2;
    localparam logic [2:0] S_DIV_M = 3'd3;
    localparam logic [2:0] S_MUL_S = 3'd4;
    localparam logic [2:0] S_DIV_S = 3'd5;
    localparam logic [2:0] S_DIV_B = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                        r_state;
    logic                              r_div_run;
    logic                              r_out_valid;
    logic [CW-1:0]                     r_pen_x;
    logic [CW-1:0]                     r_pen_y;
    logic [CW-1:0]                     r_x;
    logic [CW-1:0]                     r_y;
    logic [CW-1:0]                     r_i;
    logic [CW-1:0]                     r_len;
    logic [CW-1:0]                     r_minor;
    logic                              r_steep;
    logic                              r_falling;
    logic                              r_vert;
    logic [agl_pkg::E_W-1:0]           r_e;
    logic [agl_pkg::E_W-1:0]           r_inc;
    logic [agl_pkg::PROD_W-1:0]        r_prod;
    logic [agl_pkg::COLOR_W-1:0]       r_main_red;
    logic [agl_pkg::COLOR_W-1:0]       r_side_red;
    logic [agl_pkg::COLOR_W-1:0]       r_blue;
    logic [CW-1:0]                     r_o_main_x;
    logic [CW-1:0]                     r_o_main_y;
    logic [agl_pkg::COLOR_W-1:0]       r_o_main_red;
    logic [agl_pkg::SIDE_W-1:0]        r_o_side_x;
    logic [agl_pkg::SIDE_W-1:0]        r_o_side_y;
    logic [agl_pkg::COLOR_W-1:0]       r_o_side_red;
    logic                              r_o_side_valid;
    logic [agl_pkg::COLOR_W-1:0]       r_o_blue;
    logic                              r_o_last;

    logic                              w_take;
    logic [CW-1:0]                     w_adx;
    logic [CW-1:0]                     w_ady;
    logic                              w_steep;
    logic                              w_vert;
    logic                              w_falling;
    logic                              w_pen_first;
    logic [CW-1:0]                     w_len;
    logic [CW-1:0]                     w_rem;
    logic [agl_pkg::E_W-1:0]           w_factor;
    logic [agl_pkg::PROD_W-1:0]        w_prod;
    logic [agl_pkg::PROD_W+agl_pkg::COLOR_W-1:0] w_prod255;
    logic [agl_pkg::COLOR_NUM_W-1:0]   w_color_num;
    logic [agl_pkg::COLOR_NUM_W-1:0]   w_blue_num;
    logic [agl_pkg::DIV_W-1:0]         w_dividend;
    logic                              w_div_state;
    agl_pkg::t_div_req                 w_div_req;
    agl_pkg::t_div_rsp                 w_div_rsp;
    logic [agl_pkg::E_W:0]             w_e_sum;
    logic                              w_wrap;
    logic [agl_pkg::E_W-1:0]           w_e_next;
    logic [CW-1:0]                     w_ystep;
    logic [CW-1:0]                     w_x_next;
    logic [CW-1:0]                     w_y_next;
    logic                              w_last;
    logic                              w_load;

    assign o_stall = r_state != S_IDLE;
    assign w_take  = (r_state == S_IDLE) && i_valid;

    assign w_adx       = (i_x_coord > r_pen_x) ? i_x_coord - r_pen_x : r_pen_x - i_x_coord;
    assign w_ady       = (i_y_coord > r_pen_y) ? i_y_coord - r_pen_y : r_pen_y - i_y_coord;
    assign w_steep     = w_ady > w_adx;
    assign w_vert      = w_adx == '0;
    assign w_falling   = (i_y_coord != r_pen_y) &&
                         ((i_x_coord > r_pen_x) != (i_y_coord > r_pen_y));
    assign w_pen_first = w_steep ? (w_falling ? (r_pen_y > i_y_coord) : (r_pen_y < i_y_coord))
                                 : (r_pen_x < i_x_coord);
    assign w_len       = w_steep ? w_ady : w_adx;

    assign w_rem     = r_len - r_i;
    assign w_factor  = (r_state == S_MUL_M) ? agl_pkg::E_ONE - r_e : r_e;
    assign w_prod    = agl_pkg::PROD_W'(w_rem) * agl_pkg::PROD_W'(w_factor);
    assign w_prod255 = {r_prod, {agl_pkg::COLOR_W{1'b0}}} - {{agl_pkg::COLOR_W{1'b0}}, r_prod};
    assign w_color_num = w_prod255[FB +: agl_pkg::COLOR_NUM_W];
    assign w_blue_num  = {r_i, {agl_pkg::COLOR_W{1'b0}}} - {{agl_pkg::COLOR_W{1'b0}}, r_i};

    always_comb begin
        case (r_state)
            S_INC:   w_dividend = {r_minor, {FB{1'b0}}};
            S_DIV_B: w_dividend = agl_pkg::DIV_W'(w_blue_num);
            default: w_dividend = agl_pkg::DIV_W'(w_color_num);
        endcase
    end

    assign w_div_state = (r_state == S_INC) || (r_state == S_DIV_M) ||
                         (r_state == S_DIV_S) || (r_state == S_DIV_B);
    assign w_div_req.start    = w_div_state && !r_div_run;
    assign w_div_req.long_div = r_state == S_INC;

    agl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (r_len),
        .o_rsp      (w_div_rsp)
    );

    assign w_e_sum  = {1'b0, r_e} + {1'b0, r_inc};
    assign w_wrap   = w_e_sum >= {1'b0, agl_pkg::E_ONE};
    assign w_e_next = w_wrap ? agl_pkg::E_W'(w_e_sum - {1'b0, agl_pkg::E_ONE})
                             : w_e_sum[agl_pkg::E_W-1:0];
    assign w_ystep  = r_falling ? r_y - CW'(1) : r_y + CW'(1);

    always_comb begin
        if (r_vert) begin
            w_x_next = r_x;
            w_y_next = r_y + CW'(1);
        end else if (r_steep) begin
            w_x_next = r_x + CW'(w_wrap);
            w_y_next = w_ystep;
        end else begin
            w_x_next = r_x + CW'(1);
            w_y_next = w_wrap ? w_ystep : r_y;
        end
    end

    assign w_last = r_i == r_len - CW'(1);
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_run   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
        end else begin
            if (w_div_req.start) begin
                r_div_run <= 1'b1;
            end else if (w_div_rsp.done) begin
                r_div_run <= 1'b0;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_pen_x <= i_x_coord;
                        r_pen_y <= i_y_coord;
                        if (i_opcode && (w_len != '0)) begin
                            r_state <= w_vert ? S_MUL_M : S_INC;
                        end
                    end
                end
                S_INC: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_MUL_M;
                    end
                end
                S_MUL_M: begin
                    r_state <= S_DIV_M;
                end
                S_DIV_M: begin
                    if (w_div_rsp.done) begin
                        r_state <= r_vert ? S_DIV_B : S_MUL_S;
                    end
                end
                S_MUL_S: begin
                    r_state <= S_DIV_S;
                end
                S_DIV_S: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_state <= w_last ? S_IDLE : S_MUL_M;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_len     <= w_len;
            r_minor   <= w_steep ? w_adx : w_ady;
            r_steep   <= w_steep && !w_vert;
            r_falling <= w_falling && !w_vert;
            r_vert    <= w_vert;
            r_e       <= '0;
            r_inc     <= '0;
            r_i       <= '0;
            r_x       <= w_pen_first ? r_pen_x : i_x_coord;
            if (w_vert) begin
                r_y <= (r_pen_y < i_y_coord) ? r_pen_y : i_y_coord;
            end else begin
                r_y <= w_pen_first ? r_pen_y : i_y_coord;
            end
        end

        if ((r_state == S_INC) && w_div_rsp.done) begin
            r_inc <= w_div_rsp.quotient[agl_pkg::E_W-1:0];
        end

        if ((r_state == S_MUL_M) || (r_state == S_MUL_S)) begin
            r_prod <= w_prod;
        end

        if (w_div_rsp.done) begin
            case (r_state)
                S_DIV_M: r_main_red <= w_div_rsp.quotient[agl_pkg::COLOR_W-1:0];
                S_DIV_S: r_side_red <= w_div_rsp.quotient[agl_pkg::COLOR_W-1:0];
                S_DIV_B: r_blue     <= w_div_rsp.quotient[agl_pkg::COLOR_W-1:0];
                default: r_blue     <= r_blue;
            endcase
        end

        if (w_load) begin
            r_o_main_x     <= r_steep ? r_x + CW'(1) : r_x;
            r_o_main_y     <= (!r_steep && !r_falling && !r_vert) ? r_y + CW'(1) : r_y;
            r_o_main_red   <= r_main_red;
            r_o_side_x     <= r_vert ? '0 : agl_pkg::SIDE_W'(r_x);
            if (r_vert) begin
                r_o_side_y <= '0;
            end else if (r_falling && !r_steep) begin
                r_o_side_y <= agl_pkg::SIDE_W'(r_y) - agl_pkg::SIDE_W'(1);
            end else begin
                r_o_side_y <= agl_pkg::SIDE_W'(r_y);
            end
            r_o_side_red   <= r_vert ? '0 : r_side_red;
            r_o_side_valid <= !r_vert;
            r_o_blue       <= r_blue;
            r_o_last       <= w_last;
            r_e            <= w_e_next;
            r_x            <= w_x_next;
            r_y            <= w_y_next;
            r_i            <= r_i + CW'(1);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_main_x     = r_o_main_x;
    assign o_main_y     = r_o_main_y;
    assign o_main_red   = r_o_main_red;
    assign o_side_x     = r_o_side_x;
    assign o_side_y     = r_o_side_y;
    assign o_side_red   = r_o_side_red;
    assign o_side_valid = r_o_side_valid;
    assign o_blue_level = r_o_blue;
    assign o_last_pair  = r_o_last;

    a_error_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_e < agl_pkg::E_ONE))
        else $error("Error fraction reached one inside a line.");

    a_step_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_i < r_len))
        else $error("Step index ran past the line length.");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> ((r_state == S_INC) || (r_state == S_DIV_M) ||
                            (r_state == S_DIV_S) || (r_state == S_DIV_B)))
        else $error("Divider finished outside a division state.");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE))
        else $error("Sequencer kept running after the last pixel pair.");

endmodule

// File: test/tb_top.sv
// Testbench of the antialiased gradient line rasterizer: directed and random pen commands, predicted pairs.
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_W       = agl_pkg::COORD_W;
    localparam int COLOR_W       = agl_pkg::COLOR_W;
    localparam int SIDE_W        = agl_pkg::SIDE_W;
    localparam int FRACTION_BITS = agl_pkg::FRACTION_BITS;
    localparam int TILE_SIZE     = agl_pkg::TILE_SIZE;

    typedef enum logic {
        OP_MOVE = 1'b0,
        OP_LINE = 1'b1
    } t_pen_op;

    localparam longint unsigned FRAC_ONE = 64'd1 << FRACTION_BITS;
    localparam int RANDOM_ITEMS   = 210;
    localparam int QUIET_TAIL     = 40;
    localparam int HOLD_AT        = 40;
    localparam int PAUSE_AT       = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic [COORD_W-1:0] main_x;
        logic [COORD_W-1:0] main_y;
        logic [COLOR_W-1:0] main_red;
        logic [SIDE_W-1:0]  side_x;
        logic [SIDE_W-1:0]  side_y;
        logic [COLOR_W-1:0] side_red;
        logic               side_valid;
        logic [COLOR_W-1:0] blue_level;
        logic               last_pair;
    } t_pixel_pair;

    class t_pair_scoreboard;
        t_pixel_pair        pending_pairs[$];
        logic [COORD_W-1:0] pen_x;
        logic [COORD_W-1:0] pen_y;
        int                 errors;

        function new();
            pen_x  = '0;
            pen_y  = '0;
            errors = 0;
        endfunction

        function void push_pair(int mx, int my, int sx, int sy, bit sv,
                                longint unsigned e, longint unsigned step,
                                longint unsigned len);
            t_pixel_pair     p;
            longint unsigned rem;
            longint unsigned den;
            rem          = len - step;
            den          = len * FRAC_ONE;
            p.main_x     = mx[COORD_W-1:0];
            p.main_y     = my[COORD_W-1:0];
            p.main_red   = COLOR_W'((rem * (FRAC_ONE - e) * 255) / den);
            p.side_x     = sv ? sx[SIDE_W-1:0] : '0;
            p.side_y     = sv ? sy[SIDE_W-1:0] : '0;
            p.side_red   = sv ? COLOR_W'((rem * e * 255) / den) : '0;
            p.side_valid = sv;
            p.blue_level = COLOR_W'((step * 255) / len);
            p.last_pair  = (step + 1 == len);
            pending_pairs.push_back(p);
        endfunction

        function void note_command(t_pen_op op, logic [COORD_W-1:0] tx,
                                   logic [COORD_W-1:0] ty);
            int              ax, ay, tx_i, ty_i, dx, dy, adx, ady;
            int              major, minor, x, y;
            bit              steep, falling, pen_first;
            longint unsigned len, inc, e;
            ax     = int'(pen_x);
            ay     = int'(pen_y);
            tx_i   = int'(tx);
            ty_i   = int'(ty);
            dx     = tx_i - ax;
            dy     = ty_i - ay;
            adx    = (dx < 0) ? -dx : dx;
            ady    = (dy < 0) ? -dy : dy;
            pen_x  = tx;
            pen_y  = ty;
            if (op == OP_MOVE)
                return;
            // A vertical line draws single pixels upward from the lower row.
            if (dx == 0) begin
                y = (ay < ty_i) ? ay : ty_i;
                for (int i = 0; i < ady; i++)
                    push_pair(ax, y + i, 0, 0, 1'b0, 0, 64'(i), 64'(ady));
                return;
            end
            falling = (dy != 0) && ((dx > 0) != (dy > 0));
            steep   = ady > adx;
            major   = steep ? ady : adx;
            minor   = steep ? adx : ady;
            len     = 64'(major);
            inc     = (longint'(minor) << FRACTION_BITS) / len;
            e       = 0;
            if (steep)
                pen_first = falling ? (ay > ty_i) : (ay < ty_i);
            else
                pen_first = ax < tx_i;
            x = pen_first ? ax : tx_i;
            y = pen_first ? ay : ty_i;
            for (longint unsigned i = 0; i < len; i++) begin
                if (steep)
                    push_pair(x + 1, y, x, y, 1'b1, e, i, len);
                else if (!falling)
                    push_pair(x, y + 1, x, y, 1'b1, e, i, len);
                else
                    push_pair(x, y, x, y - 1, 1'b1, e, i, len);
                e += inc;
                if (e >= FRAC_ONE) begin
                    e -= FRAC_ONE;
                    if (steep)
                        x++;
                    else
                        y += falling ? -1 : 1;
                end
                if (steep)
                    y += falling ? -1 : 1;
                else
                    x++;
            end
        endfunction

        function bit field_ok(string name, longint unsigned want, longint unsigned got);
            if (want == got)
                return 1'b1;
            $display("%0t: pixel pair field %s mismatch, expected 'h%0h, actual 'h%0h",
                     $time, name, want, got);
            return 1'b0;
        endfunction

        function void check_pair(t_pixel_pair got);
            t_pixel_pair want;
            bit          ok;
            if (pending_pairs.size() == 0) begin
                $display("%0t: pixel pair at (%0d,%0d) with nothing expected",
                         $time, got.main_x, got.main_y);
                errors++;
                return;
            end
            want = pending_pairs.pop_front();
            ok   = 1'b1;
            ok  &= field_ok("main_x", 64'(want.main_x), 64'(got.main_x));
            ok  &= field_ok("main_y", 64'(want.main_y), 64'(got.main_y));
            ok  &= field_ok("main_red", 64'(want.main_red), 64'(got.main_red));
            ok  &= field_ok("side_x", 64'(want.side_x), 64'(got.side_x));
            ok  &= field_ok("side_y", 64'(want.side_y), 64'(got.side_y));
            ok  &= field_ok("side_red", 64'(want.side_red), 64'(got.side_red));
            ok  &= field_ok("side_valid", 64'(want.side_valid), 64'(got.side_valid));
            ok  &= field_ok("blue_level", 64'(want.blue_level), 64'(got.blue_level));
            ok  &= field_ok("last_pair", 64'(want.last_pair), 64'(got.last_pair));
            if (!ok)
                errors++;
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_opcode;
    logic [COORD_W-1:0]        i_x_coord;
    logic [COORD_W-1:0]        i_y_coord;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [COORD_W-1:0]        o_main_x;
    logic [COORD_W-1:0]        o_main_y;
    logic [COLOR_W-1:0]        o_main_red;
    logic signed [SIDE_W-1:0]  o_side_x;
    logic signed [SIDE_W-1:0]  o_side_y;
    logic [COLOR_W-1:0]        o_side_red;
    logic                      o_side_valid;
    logic [COLOR_W-1:0]        o_blue_level;
    logic                      o_last_pair;

    t_pair_scoreboard sb = new();

    bit          quiet        = 1'b0;
    bit          hold_request = 1'b0;
    bit          rx_on        = 1'b1;
    int          hold_left    = 0;
    int          stall_left   = 0;
    int          rx_cycle     = 0;
    int          idle_cycles  = 0;
    t_pixel_pair seen_pair;

    antialiased_gradient_line DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_main_x     (o_main_x),
        .o_main_y     (o_main_y),
        .o_main_red   (o_main_red),
        .o_side_x     (o_side_x),
        .o_side_y     (o_side_y),
        .o_side_red   (o_side_red),
        .o_side_valid (o_side_valid),
        .o_blue_level (o_blue_level),
        .o_last_pair  (o_last_pair)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver checks every transfer and decides its stall for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_pair.main_x     = o_main_x;
            seen_pair.main_y     = o_main_y;
            seen_pair.main_red   = o_main_red;
            seen_pair.side_x     = o_side_x;
            seen_pair.side_y     = o_side_y;
            seen_pair.side_red   = o_side_red;
            seen_pair.side_valid = o_side_valid;
            seen_pair.blue_level = o_blue_level;
            seen_pair.last_pair  = o_last_pair;
            if (sb.pending_pairs.size() == 0) begin
                sb.check_pair(seen_pair);
                $display("antialiased_gradient_line verification failed");
                $finish;
            end else begin
                sb.check_pair(seen_pair);
            end
        end
        if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (rx_cycle % 200 == 0)
            rx_on = 1'($urandom_range(0, 1));
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet && rx_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
        rx_cycle++;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("antialiased_gradient_line verification failed");
                $finish;
            end
        end
    end

    task automatic send_command(t_pen_op op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_x_coord <= x;
        i_y_coord <= y;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_command(op, x, y);
    endtask

    task automatic idle_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > TILE_SIZE - 1)
            v = TILE_SIZE - 1;
        return v[COORD_W-1:0];
    endfunction

    initial begin : stimulus
        t_pen_op            op;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        int                 pick;
        bit                 gap_on;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_opcode  = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        gap_on    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(OP_LINE, 0, 0);
        send_command(OP_LINE, 63, 0);
        send_command(OP_MOVE, 0, 63);
        send_command(OP_LINE, 63, 63);
        send_command(OP_LINE, 63, 0);
        send_command(OP_LINE, 0, 63);
        send_command(OP_MOVE, 0, 0);
        send_command(OP_LINE, 63, 63);
        send_command(OP_MOVE, 10, 0);
        send_command(OP_LINE, 20, 63);
        send_command(OP_LINE, 0, 10);
        send_command(OP_MOVE, 5, 60);
        send_command(OP_LINE, 30, 2);
        send_command(OP_LINE, 0, 40);
        send_command(OP_LINE, 50, 10);
        send_command(OP_LINE, 7, 3);
        send_command(OP_LINE, 7, 40);
        send_command(OP_LINE, 7, 40);
        send_command(OP_LINE, 8, 41);
        send_command(OP_LINE, 8, 42);
        send_command(OP_LINE, 9, 42);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
            if (n % 16 == 0)
                gap_on = 1'($urandom_range(0, 1));
            if (n == PAUSE_AT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending_pairs.size() != 0)
                    @(posedge i_clk);
            end else if (!quiet && gap_on && $urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 18));
            end
            pick = $urandom_range(0, 99);
            op   = OP_LINE;
            tx   = sb.pen_x;
            ty   = sb.pen_y;
            if (n == HOLD_AT) begin
                // A long line while the receiver holds off backs the block up.
                hold_request = 1'b1;
                tx           = (sb.pen_x < 32) ? 63 : 0;
            end else if (pick < 25) begin
                op = OP_MOVE;
                tx = COORD_W'($urandom_range(0, 63));
                ty = COORD_W'($urandom_range(0, 63));
            end else if (pick < 35) begin
                ty = COORD_W'($urandom_range(0, 63));
            end else if (pick < 45) begin
                tx = COORD_W'($urandom_range(0, 63));
            end else if (pick < 80) begin
                tx = near_coord(sb.pen_x);
                ty = near_coord(sb.pen_y);
            end else if (pick >= 84) begin
                tx = COORD_W'($urandom_range(0, 63));
                ty = COORD_W'($urandom_range(0, 63));
            end
            send_command(op, tx, ty);
        end

        i_valid <= 1'b0;
        while (sb.pending_pairs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_pairs.size() == 0)
            $display("antialiased_gradient_line verification clean");
        else
            $display("antialiased_gradient_line verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/agl_pkg.sv
rtl/agl_div.sv
rtl/antialiased_gradient_line.sv
test/tb_top.sv
